[sv/srrc_pkg.sv]
// ----------------------------------------------------------------------------
// srrc_pkg
// Shared constants and types for the swept rectangle collision pipeline.
// ----------------------------------------------------------------------------
package srrc_pkg;

    localparam int COORD_W  = 20;
    localparam int SIZE_W   = 18;
    localparam int DELTA_W  = 23;
    localparam int ORG_W    = 22;
    localparam int TFRAC    = 16;
    localparam int NUM_W    = DELTA_W + TFRAC;
    localparam int QBITS    = NUM_W;
    localparam int QUO_W    = QBITS + 1;
    localparam int DIV_LAT  = QBITS + 2;
    localparam int TIME_W   = 42;
    localparam int PT_W     = 24;
    localparam int CT_W     = 32;
    localparam int IN_W     = 192;
    localparam int OUT_W    = 136;

    localparam logic signed [TIME_W-1:0] TIME_INF = 42'sh100_0000_0000;

    typedef enum logic [2:0] {
        NRM_NONE    = 3'd0,
        NRM_PLUS_X  = 3'd1,
        NRM_MINUS_X = 3'd2,
        NRM_PLUS_Y  = 3'd3,
        NRM_MINUS_Y = 3'd4
    } t_normal;

    typedef struct packed {
        logic                      valid;
        logic                      still;
        logic                      miss_x;
        logic                      miss_y;
        logic                      dnx_neg;
        logic                      dfx_neg;
        logic                      dny_neg;
        logic                      dfy_neg;
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
        logic signed [ORG_W-1:0]   ox2;
        logic signed [ORG_W-1:0]   oy2;
    } t_side;

endpackage

[sv/srrc_div.sv]
// ----------------------------------------------------------------------------
// srrc_div
// Pipelined restoring divider, one quotient bit per stage, truncating toward
// zero: quotient = dividend * 2^16 / divisor.
// ----------------------------------------------------------------------------
module srrc_div (
    input  logic                                    i_clk,
    input  logic                                    i_ce,
    input  logic signed [srrc_pkg::DELTA_W-1:0]     i_dividend,
    input  logic signed [srrc_pkg::COORD_W-1:0]     i_divisor,
    output logic signed [srrc_pkg::QUO_W-1:0]       o_quotient
);

    logic [srrc_pkg::NUM_W-1:0]   r_num0;
    logic [srrc_pkg::COORD_W-1:0] r_den0;
    logic                         r_neg0;

    logic [srrc_pkg::COORD_W-1:0] r_rem [srrc_pkg::QBITS];
    logic [srrc_pkg::NUM_W-1:0]   r_num [srrc_pkg::QBITS];
    logic [srrc_pkg::QBITS-1:0]   r_quo [srrc_pkg::QBITS];
    logic [srrc_pkg::COORD_W-1:0] r_den [srrc_pkg::QBITS];
    logic                         r_neg [srrc_pkg::QBITS];
    logic signed [srrc_pkg::QUO_W-1:0] r_q;

    logic [srrc_pkg::DELTA_W-1:0] abs_d;
    logic [srrc_pkg::COORD_W-1:0] abs_v;

    assign abs_d = i_dividend[srrc_pkg::DELTA_W-1] ? srrc_pkg::DELTA_W'(-i_dividend)
                                                   : srrc_pkg::DELTA_W'(i_dividend);
    assign abs_v = i_divisor[srrc_pkg::COORD_W-1] ? srrc_pkg::COORD_W'(-i_divisor)
                                                  : srrc_pkg::COORD_W'(i_divisor);

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_num0 <= {abs_d, srrc_pkg::TFRAC'(0)};
            r_den0 <= abs_v;
            r_neg0 <= i_dividend[srrc_pkg::DELTA_W-1] ^ i_divisor[srrc_pkg::COORD_W-1];
        end
    end

    for (genvar k = 0; k < srrc_pkg::QBITS; k++) begin : g_stage
        logic [srrc_pkg::COORD_W-1:0] rem_in;
        logic [srrc_pkg::NUM_W-1:0]   num_in;
        logic [srrc_pkg::QBITS-1:0]   quo_in;
        logic [srrc_pkg::COORD_W-1:0] den_in;
        logic                         neg_in;
        logic [srrc_pkg::COORD_W:0]   trial;
        logic                         ge;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = r_num0;
            assign quo_in = '0;
            assign den_in = r_den0;
            assign neg_in = r_neg0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign num_in = r_num[k-1];
            assign quo_in = r_quo[k-1];
            assign den_in = r_den[k-1];
            assign neg_in = r_neg[k-1];
        end

        assign trial = {rem_in, num_in[srrc_pkg::NUM_W-1]};
        assign ge    = trial >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k] <= ge ? srrc_pkg::COORD_W'(trial - {1'b0, den_in})
                               : trial[srrc_pkg::COORD_W-1:0];
                r_num[k] <= {num_in[srrc_pkg::NUM_W-2:0], 1'b0};
                r_quo[k] <= {quo_in[srrc_pkg::QBITS-2:0], ge};
                r_den[k] <= den_in;
                r_neg[k] <= neg_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_q <= r_neg[srrc_pkg::QBITS-1]
                 ? srrc_pkg::QUO_W'(-$signed({1'b0, r_quo[srrc_pkg::QBITS-1]}))
                 : $signed({1'b0, r_quo[srrc_pkg::QBITS-1]});
        end
    end

    assign o_quotient = r_q;

endmodule

[sv/swept_rect_vs_rect_collision_unit.sv]
// ----------------------------------------------------------------------------
// swept_rect_vs_rect_collision_unit
// Swept rectangle against rectangle slab test in fixed point, fully pipelined.
//
//   channel   dir  width  content
//   s_axis    in   192    one query: source, velocity, target
//   m_axis    out  136    hit, points, contact time, normal
//
// one query per cycle unless a stall on m_axis holds the pipeline
// a stall on m_axis freezes every stage at once; nothing is dropped
// synchronous active-low reset clears the valid bits only
// ----------------------------------------------------------------------------
module swept_rect_vs_rect_collision_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // src_x, src_y, src_width, src_height, vel_x, vel_y,
    // tgt_x, tgt_y, tgt_width, tgt_height
    input  logic [srrc_pkg::IN_W-1:0]    i_s_axis_tdata,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // hit, points_valid, near_x, near_y, far_x, far_y, contact_time,
    // normal_code, zero pad
    output logic [srrc_pkg::OUT_W-1:0]   o_m_axis_tdata
);

    logic ce;

    // stage a
    logic signed [srrc_pkg::COORD_W-1:0] sx, sy, vx, vy, tx, ty;
    logic        [srrc_pkg::SIZE_W-1:0]  sw, sh, tw, th;
    logic signed [srrc_pkg::DELTA_W-1:0] dnx, dfx, dny, dfy;
    srrc_pkg::t_side n_a;

    srrc_pkg::t_side r_a;
    logic signed [srrc_pkg::DELTA_W-1:0] r_dnx, r_dfx, r_dny, r_dfy;
    srrc_pkg::t_side r_dly [srrc_pkg::DIV_LAT];

    logic signed [srrc_pkg::QUO_W-1:0] qnx, qfx, qny, qfy;

    // stage b
    srrc_pkg::t_side sd;
    logic signed [srrc_pkg::TIME_W-1:0] ax, bx, ay, by;
    logic r_b_valid, r_b_miss;
    logic signed [srrc_pkg::TIME_W-1:0] r_tnx, r_tfx, r_tny, r_tfy;
    logic signed [srrc_pkg::COORD_W-1:0] r_b_vx, r_b_vy;
    logic signed [srrc_pkg::ORG_W-1:0]   r_b_ox2, r_b_oy2;

    // stage c
    logic signed [srrc_pkg::TIME_W-1:0] tnear, tfar;
    logic c_pv, c_hit;
    srrc_pkg::t_normal c_code;
    logic [srrc_pkg::CT_W-1:0] c_ct;
    logic r_c_valid, r_c_pv, r_c_hit;
    srrc_pkg::t_normal r_c_code;
    logic [srrc_pkg::CT_W-1:0] r_c_ct;
    logic signed [srrc_pkg::QUO_W-1:0] r_c_tn, r_c_tf;
    logic signed [srrc_pkg::COORD_W-1:0] r_c_vx, r_c_vy;
    logic signed [srrc_pkg::ORG_W-1:0]   r_c_ox2, r_c_oy2;

    // stage d
    logic signed [srrc_pkg::COORD_W-1:0] d_v [4];
    logic signed [srrc_pkg::QUO_W-1:0]   d_t [4];
    logic signed [srrc_pkg::ORG_W-1:0]   d_o [4];
    logic r_d_valid, r_d_pv, r_d_hit;
    srrc_pkg::t_normal r_d_code;
    logic [srrc_pkg::CT_W-1:0] r_d_ct;
    logic signed [40:0] r_plo [4];
    logic signed [39:0] r_phi [4];
    logic signed [srrc_pkg::ORG_W-1:0] r_d_org [4];

    // stage e
    logic r_e_valid, r_e_pv, r_e_hit;
    srrc_pkg::t_normal r_e_code;
    logic [srrc_pkg::CT_W-1:0] r_e_ct;
    logic signed [60:0] r_p [4];
    logic signed [srrc_pkg::ORG_W-1:0] r_e_org [4];

    // stage f
    logic signed [62:0] p2 [4];
    logic signed [45:0] ps [4];
    logic [srrc_pkg::PT_W-1:0] pt [4];
    logic r_o_valid, r_o_pv, r_o_hit;
    srrc_pkg::t_normal r_o_code;
    logic [srrc_pkg::CT_W-1:0] r_o_ct;
    logic [srrc_pkg::PT_W-1:0] r_o_pt [4];

    assign ce = !r_o_valid || i_m_axis_tready;
    assign o_s_axis_tready = ce;

    // ---- stage a: slab deltas and origins
    assign sx = i_s_axis_tdata[19:0];
    assign sy = i_s_axis_tdata[39:20];
    assign sw = i_s_axis_tdata[57:40];
    assign sh = i_s_axis_tdata[75:58];
    assign vx = i_s_axis_tdata[95:76];
    assign vy = i_s_axis_tdata[115:96];
    assign tx = i_s_axis_tdata[135:116];
    assign ty = i_s_axis_tdata[155:136];
    assign tw = i_s_axis_tdata[173:156];
    assign th = i_s_axis_tdata[191:174];

    always_comb begin
        dnx = srrc_pkg::DELTA_W'(tx) - srrc_pkg::DELTA_W'(sx)
            - srrc_pkg::DELTA_W'({1'b0, sw});
        dfx = srrc_pkg::DELTA_W'(tx) + srrc_pkg::DELTA_W'({1'b0, tw})
            - srrc_pkg::DELTA_W'(sx);
        dny = srrc_pkg::DELTA_W'(ty) - srrc_pkg::DELTA_W'(sy)
            - srrc_pkg::DELTA_W'({1'b0, sh});
        dfy = srrc_pkg::DELTA_W'(ty) + srrc_pkg::DELTA_W'({1'b0, th})
            - srrc_pkg::DELTA_W'(sy);
        n_a.valid   = i_s_axis_tvalid;
        n_a.still   = (vx == '0) && (vy == '0);
        n_a.miss_x  = (vx == '0) && ((dnx == '0) || (dfx == '0));
        n_a.miss_y  = (vy == '0) && ((dny == '0) || (dfy == '0));
        n_a.dnx_neg = dnx[srrc_pkg::DELTA_W-1];
        n_a.dfx_neg = dfx[srrc_pkg::DELTA_W-1];
        n_a.dny_neg = dny[srrc_pkg::DELTA_W-1];
        n_a.dfy_neg = dfy[srrc_pkg::DELTA_W-1];
        n_a.vx      = vx;
        n_a.vy      = vy;
        n_a.ox2     = (srrc_pkg::ORG_W'(sx) <<< 1) + srrc_pkg::ORG_W'({1'b0, sw});
        n_a.oy2     = (srrc_pkg::ORG_W'(sy) <<< 1) + srrc_pkg::ORG_W'({1'b0, sh});
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_dnx <= dnx;
            r_dfx <= dfx;
            r_dny <= dny;
            r_dfy <= dfy;
        end
    end

    srrc_div u_div_nx (.i_clk, .i_ce(ce), .i_dividend(r_dnx), .i_divisor(r_a.vx),
                       .o_quotient(qnx));
    srrc_div u_div_fx (.i_clk, .i_ce(ce), .i_dividend(r_dfx), .i_divisor(r_a.vx),
                       .o_quotient(qfx));
    srrc_div u_div_ny (.i_clk, .i_ce(ce), .i_dividend(r_dny), .i_divisor(r_a.vy),
                       .o_quotient(qny));
    srrc_div u_div_fy (.i_clk, .i_ce(ce), .i_dividend(r_dfy), .i_divisor(r_a.vy),
                       .o_quotient(qfy));

    // ---- stage b: slab times with infinities
    assign sd = r_dly[srrc_pkg::DIV_LAT-1];

    always_comb begin
        ax = (sd.vx == '0) ? (sd.dnx_neg ? -srrc_pkg::TIME_INF : srrc_pkg::TIME_INF)
                           : srrc_pkg::TIME_W'(qnx);
        bx = (sd.vx == '0) ? (sd.dfx_neg ? -srrc_pkg::TIME_INF : srrc_pkg::TIME_INF)
                           : srrc_pkg::TIME_W'(qfx);
        ay = (sd.vy == '0) ? (sd.dny_neg ? -srrc_pkg::TIME_INF : srrc_pkg::TIME_INF)
                           : srrc_pkg::TIME_W'(qny);
        by = (sd.vy == '0) ? (sd.dfy_neg ? -srrc_pkg::TIME_INF : srrc_pkg::TIME_INF)
                           : srrc_pkg::TIME_W'(qfy);
    end

    // ---- stage c: overlap, near and far, normal
    always_comb begin
        tnear  = (r_tnx > r_tny) ? r_tnx : r_tny;
        tfar   = (r_tfx < r_tfy) ? r_tfx : r_tfy;
        c_pv   = !r_b_miss && (r_tnx < r_tfy) && (r_tny < r_tfx);
        c_hit  = c_pv && !tfar[srrc_pkg::TIME_W-1];
        c_code = srrc_pkg::NRM_NONE;
        if (c_hit) begin
            if (r_tnx > r_tny) begin
                c_code = r_b_vx[srrc_pkg::COORD_W-1] ? srrc_pkg::NRM_PLUS_X
                                                     : srrc_pkg::NRM_MINUS_X;
            end else if (r_tnx < r_tny) begin
                c_code = r_b_vy[srrc_pkg::COORD_W-1] ? srrc_pkg::NRM_PLUS_Y
                                                     : srrc_pkg::NRM_MINUS_Y;
            end
        end
        if (!c_pv) begin
            c_ct = '0;
        end else if (tnear > 42'sd2147483647) begin
            c_ct = 32'h7fff_ffff;
        end else if (tnear < -42'sh0_0000_8000_0000) begin
            c_ct = 32'h8000_0000;
        end else begin
            c_ct = tnear[srrc_pkg::CT_W-1:0];
        end
    end

    // ---- stage d: partial products
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            d_v[j] = (j % 2 == 0) ? r_c_vx : r_c_vy;
            d_o[j] = (j % 2 == 0) ? r_c_ox2 : r_c_oy2;
            d_t[j] = (j < 2) ? r_c_tn : r_c_tf;
        end
    end

    // ---- stage f: rounding and saturation
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            p2[j] = (63'(r_e_org[j]) <<< 16) + (63'(r_p[j]) <<< 1) + 63'sd65536;
            ps[j] = 46'(p2[j] >>> 17);
            if (!r_e_pv) begin
                pt[j] = '0;
            end else if (ps[j] > 46'sd8388607) begin
                pt[j] = 24'h7f_ffff;
            end else if (ps[j] < -46'sd8388608) begin
                pt[j] = 24'h80_0000;
            end else begin
                pt[j] = ps[j][srrc_pkg::PT_W-1:0];
            end
        end
    end

    // valid bits and payload
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_a[$bits(srrc_pkg::t_side)-2:0] <= n_a[$bits(srrc_pkg::t_side)-2:0];
            r_dly[0][$bits(srrc_pkg::t_side)-2:0] <= r_a[$bits(srrc_pkg::t_side)-2:0];
            for (int k = 1; k < srrc_pkg::DIV_LAT; k++) begin
                r_dly[k][$bits(srrc_pkg::t_side)-2:0] <=
                    r_dly[k-1][$bits(srrc_pkg::t_side)-2:0];
            end

            r_b_miss <= sd.still || sd.miss_x || sd.miss_y;
            r_tnx    <= (ax > bx) ? bx : ax;
            r_tfx    <= (ax > bx) ? ax : bx;
            r_tny    <= (ay > by) ? by : ay;
            r_tfy    <= (ay > by) ? ay : by;
            r_b_vx   <= sd.vx;
            r_b_vy   <= sd.vy;
            r_b_ox2  <= sd.ox2;
            r_b_oy2  <= sd.oy2;

            r_c_pv   <= c_pv;
            r_c_hit  <= c_hit;
            r_c_code <= c_code;
            r_c_ct   <= c_ct;
            r_c_tn   <= tnear[srrc_pkg::QUO_W-1:0];
            r_c_tf   <= tfar[srrc_pkg::QUO_W-1:0];
            r_c_vx   <= r_b_vx;
            r_c_vy   <= r_b_vy;
            r_c_ox2  <= r_b_ox2;
            r_c_oy2  <= r_b_oy2;

            r_d_pv   <= r_c_pv;
            r_d_hit  <= r_c_hit;
            r_d_code <= r_c_code;
            r_d_ct   <= r_c_ct;
            for (int j = 0; j < 4; j++) begin
                r_plo[j]   <= 41'(d_v[j]) * $signed({21'd0, d_t[j][19:0]});
                r_phi[j]   <= 40'(d_v[j]) * 40'($signed(d_t[j][srrc_pkg::QUO_W-1:20]));
                r_d_org[j] <= d_o[j];
            end

            r_e_pv   <= r_d_pv;
            r_e_hit  <= r_d_hit;
            r_e_code <= r_d_code;
            r_e_ct   <= r_d_ct;
            for (int j = 0; j < 4; j++) begin
                r_p[j]     <= (61'(r_phi[j]) <<< 20) + 61'(r_plo[j]);
                r_e_org[j] <= r_d_org[j];
            end

            r_o_pv   <= r_e_pv;
            r_o_hit  <= r_e_hit;
            r_o_code <= r_e_code;
            r_o_ct   <= r_e_ct;
            for (int j = 0; j < 4; j++) begin
                r_o_pt[j] <= pt[j];
            end
        end

        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
            for (int k = 0; k < srrc_pkg::DIV_LAT; k++) begin
                r_dly[k].valid <= 1'b0;
            end
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (ce) begin
            r_a.valid <= n_a.valid;
            r_dly[0].valid <= r_a.valid;
            for (int k = 1; k < srrc_pkg::DIV_LAT; k++) begin
                r_dly[k].valid <= r_dly[k-1].valid;
            end
            r_b_valid <= sd.valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
            r_o_valid <= r_e_valid;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {3'b000, r_o_code, r_o_ct, r_o_pt[3], r_o_pt[2],
                              r_o_pt[1], r_o_pt[0], r_o_pv, r_o_hit};

`ifndef SYNTHESIS
    a_hit_has_points: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_hit |-> r_o_pv)
        else $error("hit without points");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !r_o_pv |-> (r_o_ct == '0) && (r_o_pt[0] == '0) && (r_o_pt[3] == '0))
        else $error("miss with nonzero result");

    a_normal_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && (r_o_code != srrc_pkg::NRM_NONE) |-> r_o_hit)
        else $error("normal without hit");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_valid && !ce |=> r_e_valid && $stable(r_p[0]))
        else $error("pipeline moved while stalled");
`endif

endmodule

[tb/sv/tb_swept_rect_vs_rect_collision_unit.sv]
// ----------------------------------------------------------------------------
// tb_swept_rect_vs_rect_collision_unit
// Self-checking bench for the swept rectangle collision pipeline.
// Queries go through a queue-fed stream driver. Each accepted query is
// predicted in fixed point by the slab test. Results from the monitor are
// compared field by field in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_swept_rect_vs_rect_collision_unit;

    localparam longint TONE     = 64'sd65536;
    localparam longint TINF     = 64'sd1 <<< 50;
    localparam int     N_RAND   = 1150;
    localparam int     DRAIN_AT = 600;
    localparam int     WD_LIMIT = 5000;

    typedef struct {
        logic       hit;
        logic       pts_ok;
        logic [23:0] near_x;
        logic [23:0] near_y;
        logic [23:0] far_x;
        logic [23:0] far_y;
        logic [31:0] ctime;
        srrc_pkg::t_normal nrm;
    } t_collision;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [srrc_pkg::IN_W-1:0]  i_s_axis_tdata = '0;
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic [srrc_pkg::OUT_W-1:0] o_m_axis_tdata;

    logic [srrc_pkg::IN_W-1:0] query_q[$];
    t_collision      expected_q[$];
    int  sent_cnt = 0;
    int  gap_cnt = 0;
    int  stall_cnt = 0;
    int  quiet_cnt = 0;
    bit  failed = 0;
    bit  lazy_src = 1;
    bit  lazy_snk = 1;

    swept_rect_vs_rect_collision_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [srrc_pkg::IN_W-1:0] pack_query(int sx, int sy, int sw, int sh,
                                                             int vx, int vy, int tx, int ty,
                                                             int tw, int th);
        logic [srrc_pkg::IN_W-1:0] d;
        d = '0;
        d[19:0]    = sx[19:0];
        d[39:20]   = sy[19:0];
        d[57:40]   = sw[17:0];
        d[75:58]   = sh[17:0];
        d[95:76]   = vx[19:0];
        d[115:96]  = vy[19:0];
        d[135:116] = tx[19:0];
        d[155:136] = ty[19:0];
        d[173:156] = tw[17:0];
        d[191:174] = th[17:0];
        return d;
    endfunction

    function automatic bit slab_times(longint dn, longint df, longint v,
                                      output longint tn, output longint tf);
        longint a;
        longint b;
        tn = 0;
        tf = 0;
        if (v == 0) begin
            if (dn == 0 || df == 0) return 0;
            a = (dn < 0) ? -TINF : TINF;
            b = (df < 0) ? -TINF : TINF;
        end else begin
            a = (dn * TONE) / v;
            b = (df * TONE) / v;
        end
        if (a > b) begin
            tn = b;
            tf = a;
        end else begin
            tn = a;
            tf = b;
        end
        return 1;
    endfunction

    function automatic logic [23:0] swept_point(longint org2, longint v, longint t);
        longint p;
        p = (org2 * TONE + 2 * v * t + TONE) >>> 17;
        if (p > 64'sd8388607) p = 64'sd8388607;
        if (p < -64'sd8388608) p = -64'sd8388608;
        return p[23:0];
    endfunction

    function automatic t_collision sweep_collide(logic [srrc_pkg::IN_W-1:0] d);
        t_collision r;
        longint sx, sy, sw, sh, vx, vy, tx, ty, tw, th;
        longint tnx, tfx, tny, tfy, tnear, tfar, tc;
        sx = longint'($signed(d[19:0]));
        sy = longint'($signed(d[39:20]));
        sw = longint'(d[57:40]);
        sh = longint'(d[75:58]);
        vx = longint'($signed(d[95:76]));
        vy = longint'($signed(d[115:96]));
        tx = longint'($signed(d[135:116]));
        ty = longint'($signed(d[155:136]));
        tw = longint'(d[173:156]);
        th = longint'(d[191:174]);
        r = '{nrm: srrc_pkg::NRM_NONE, default: '0};
        if (vx == 0 && vy == 0) return r;
        if (!slab_times(tx - sx - sw, tx + tw - sx, vx, tnx, tfx)) return r;
        if (!slab_times(ty - sy - sh, ty + th - sy, vy, tny, tfy)) return r;
        if (!(tnx < tfy && tny < tfx)) return r;
        tnear = (tnx > tny) ? tnx : tny;
        tfar  = (tfx < tfy) ? tfx : tfy;
        r.pts_ok = 1'b1;
        r.near_x = swept_point(2 * sx + sw, vx, tnear);
        r.near_y = swept_point(2 * sy + sh, vy, tnear);
        r.far_x  = swept_point(2 * sx + sw, vx, tfar);
        r.far_y  = swept_point(2 * sy + sh, vy, tfar);
        tc = tnear;
        if (tc > 64'sd2147483647) tc = 64'sd2147483647;
        if (tc < -64'sd2147483648) tc = -64'sd2147483648;
        r.ctime = tc[31:0];
        if (tfar < 0) return r;
        r.hit = 1'b1;
        if (tnx > tny) r.nrm = (vx < 0) ? srrc_pkg::NRM_PLUS_X : srrc_pkg::NRM_MINUS_X;
        else if (tnx < tny) r.nrm = (vy < 0) ? srrc_pkg::NRM_PLUS_Y : srrc_pkg::NRM_MINUS_Y;
        return r;
    endfunction

    function automatic int rnd_s(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // source: queue-fed stream driver
    always @(posedge i_clk) begin
        int n_sent;
        int n_gap;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!(i_s_axis_tvalid && !o_s_axis_tready)) begin
            n_sent = sent_cnt;
            n_gap  = gap_cnt;
            if (i_s_axis_tvalid) begin
                expected_q.push_back(sweep_collide(i_s_axis_tdata));
                n_sent = sent_cnt + 1;
                n_gap  = lazy_src ? int'($urandom_range(0, 14)) : 0;
            end else if (gap_cnt != 0) begin
                n_gap = gap_cnt - 1;
            end
            if (n_gap == 0 && query_q.size() != 0 &&
                !(n_sent == DRAIN_AT && expected_q.size() != 0)) begin
                i_s_axis_tdata  <= query_q.pop_front();
                i_s_axis_tvalid <= 1'b1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
            sent_cnt <= n_sent;
            gap_cnt  <= n_gap;
            if (sent_cnt % 97 == 0) lazy_src <= $urandom_range(0, 2) != 0;
        end
    end

    // sink: monitor and checker
    always @(posedge i_clk) begin
        t_collision e;
        int n_stall;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected transaction %h", $time, o_m_axis_tdata);
                failed = 1;
            end else begin
                e = expected_q.pop_front();
                if (o_m_axis_tdata[0] !== e.hit) begin
                    $display("%0t: hit exp %b got %b", $time, e.hit, o_m_axis_tdata[0]);
                    failed = 1;
                end
                if (o_m_axis_tdata[1] !== e.pts_ok) begin
                    $display("%0t: points_valid exp %b got %b", $time, e.pts_ok,
                             o_m_axis_tdata[1]);
                    failed = 1;
                end
                if (o_m_axis_tdata[25:2] !== e.near_x) begin
                    $display("%0t: near_x exp %h got %h", $time, e.near_x,
                             o_m_axis_tdata[25:2]);
                    failed = 1;
                end
                if (o_m_axis_tdata[49:26] !== e.near_y) begin
                    $display("%0t: near_y exp %h got %h", $time, e.near_y,
                             o_m_axis_tdata[49:26]);
                    failed = 1;
                end
                if (o_m_axis_tdata[73:50] !== e.far_x) begin
                    $display("%0t: far_x exp %h got %h", $time, e.far_x,
                             o_m_axis_tdata[73:50]);
                    failed = 1;
                end
                if (o_m_axis_tdata[97:74] !== e.far_y) begin
                    $display("%0t: far_y exp %h got %h", $time, e.far_y,
                             o_m_axis_tdata[97:74]);
                    failed = 1;
                end
                if (o_m_axis_tdata[129:98] !== e.ctime) begin
                    $display("%0t: contact_time exp %h got %h", $time, e.ctime,
                             o_m_axis_tdata[129:98]);
                    failed = 1;
                end
                if (o_m_axis_tdata[132:130] !== e.nrm) begin
                    $display("%0t: normal_code exp %0d got %0d", $time, e.nrm,
                             o_m_axis_tdata[132:130]);
                    failed = 1;
                end
            end
            n_stall = lazy_snk ? int'($urandom_range(0, 14)) : 0;
            stall_cnt <= (n_stall == 0) ? 0 : n_stall - 1;
            i_m_axis_tready <= (n_stall == 0);
            if ($urandom_range(0, 80) == 0) lazy_snk <= !lazy_snk;
        end else if (stall_cnt != 0) begin
            stall_cnt <= stall_cnt - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt >= WD_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int sx, sy, sw, sh, vx, vy, tx, ty, tw, th;
        // directed
        query_q.push_back(pack_query(0, 0, 16, 16, 0, 0, 100, 0, 16, 16));
        query_q.push_back(pack_query(0, 0, 16, 16, 0, 160, 16, 100, 16, 16));
        query_q.push_back(pack_query(0, 0, 16, 16, 0, 160, -16, 100, 16, 16));
        query_q.push_back(pack_query(0, 0, 16, 16, 0, 160, -8, 100, 32, 16));
        query_q.push_back(pack_query(0, 0, 16, 16, 160, 0, 100, 16, 16, 16));
        query_q.push_back(pack_query(0, 0, 16, 16, 320, 0, 100, -4, 16, 16));
        query_q.push_back(pack_query(0, 0, 16, 16, -320, 0, -100, -4, 16, 16));
        query_q.push_back(pack_query(0, 0, 16, 16, 0, -320, -4, -100, 16, 16));
        query_q.push_back(pack_query(0, 0, 16, 16, 160, 160, 100, 100, 16, 16));
        query_q.push_back(pack_query(0, 0, 16, 16, 160, 0, 100, 500, 16, 16));
        query_q.push_back(pack_query(200, 0, 16, 16, 160, 0, 0, 0, 16, 16));
        query_q.push_back(pack_query(0, 0, 16, 16, 1, 1, 524287, 524287, 262143, 262143));
        query_q.push_back(pack_query(-524288, -524288, 262143, 262143, 524287, 524287,
                                     524287, 524287, 262143, 262143));
        query_q.push_back(pack_query(524287, 524287, 262143, 262143, -524288, -524288,
                                     -524288, -524288, 262143, 262143));
        query_q.push_back(pack_query(524287, -524288, 0, 0, -1, 1,
                                     -524288, 524287, 0, 0));
        query_q.push_back(pack_query(0, 0, 0, 0, 1, 0, 100, -50, 262143, 262143));
        query_q.push_back(pack_query(-524288, 0, 262143, 16, 1, -1, 524287, -40, 0, 80));
        query_q.push_back(pack_query(10, 10, 20, 20, 5, 3, 0, 0, 40, 40));
        query_q.push_back(pack_query(-1, -1, 262143, 262143, -524288, 524287,
                                     -1, -1, 262143, 262143));
        // random
        repeat (N_RAND) begin
            if ($urandom_range(0, 3) == 0) begin
                sx = $urandom; sy = $urandom; sw = $urandom; sh = $urandom;
                vx = $urandom; vy = $urandom; tx = $urandom; ty = $urandom;
                tw = $urandom; th = $urandom;
                if ($urandom_range(0, 4) == 0) vx = 0;
                if ($urandom_range(0, 4) == 0) vy = 0;
            end else begin
                sx = rnd_s(-4000, 4000); sy = rnd_s(-4000, 4000);
                sw = rnd_s(0, 400); sh = rnd_s(0, 400);
                tx = sx + rnd_s(-3000, 3000); ty = sy + rnd_s(-3000, 3000);
                tw = rnd_s(0, 600); th = rnd_s(0, 600);
                vx = tx - sx + rnd_s(-300, 300);
                vy = ty - sy + rnd_s(-300, 300);
                if ($urandom_range(0, 9) == 0) vx = 0;
                else if ($urandom_range(0, 9) == 0) vy = 0;
                if ($urandom_range(0, 7) == 0) begin
                    vx = -vx;
                    vy = -vy;
                end
                if ($urandom_range(0, 7) == 0) begin
                    vx = vx / 64;
                    vy = vy / 64;
                end
            end
            query_q.push_back(pack_query(sx, sy, sw, sh, vx, vy, tx, ty, tw, th));
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (query_q.size() == 0 && !i_s_axis_tvalid);
        @(posedge i_clk);
        wait (expected_q.size() == 0);
        repeat (60) @(posedge i_clk);
        if (!failed && expected_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[swept_rect_vs_rect_collision_unit.f]
sv/srrc_pkg.sv
sv/srrc_div.sv
sv/swept_rect_vs_rect_collision_unit.sv
tb/sv/tb_swept_rect_vs_rect_collision_unit.sv
